### hw/rtl/smbq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbq_pkg: shared types and constants
// Field widths, item kinds, status codes and register indexes of the queue.
// ----------------------------------------------------------------------------
package smbq_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int AXIS_COUNT  = 5;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int AX_W        = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
	localparam int AMEM_DEPTH  = QUEUE_DEPTH * AXIS_COUNT;
	localparam int AMEM_W      = $clog2(AMEM_DEPTH);

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_COMMIT = 2'd1,
		KIND_MCODE  = 2'd2,
		KIND_POP    = 2'd3
	} kind_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [2:0] REG_SPM_X  = 3'd0;
	localparam logic [2:0] REG_SPM_Y  = 3'd1;
	localparam logic [2:0] REG_SPM_Z  = 3'd2;
	localparam logic [2:0] REG_SPD    = 3'd3;
	localparam logic [2:0] REG_FEED_K = 3'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  axis_index;
		logic [31:0] target_position;
		logic [31:0] current_position;
		logic [31:0] feed_rate;
		logic [7:0]  mcode_number;
		logic [31:0] spindle_speed;
		logic [31:0] mcode_argument;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        mcode_flag;
		logic [2:0]  out_axis;
		logic [30:0] step_count;
		logic        direction;
		logic [30:0] peak_steps;
		logic [31:0] feed_cycles;
		logic [7:0]  out_mcode;
		logic [31:0] out_speed;
		logic [31:0] out_argument;
		logic [3:0]  fill_level;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] data;
	} cfg_word_t;
endpackage

### hw/rtl/smbq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbq_if: valid/ready channel
// Carries one payload word per handshake.
// ----------------------------------------------------------------------------
interface smbq_in_if import smbq_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface smbq_out_if import smbq_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface smbq_cfg_if import smbq_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/stepper_motion_block_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_motion_block_queue: motion block ring queue
// Stages axis step counts, enqueues linear and M-code blocks, pops them.
// ----------------------------------------------------------------------------
// Usage: items enter on in_ch, result words leave on out_ch, registers are
// written on cfg (index and data); the user is to write them only while the
// block is idle, which the block itself does not enforce. An item is taken
// only when the sequencer is idle and the previous result word has been taken;
// it then runs around one shared unit: a 33x16 partial product multiplier for
// loads, a restoring divider one quotient bit a cycle for commits, and an axis
// sweep of one axis store entry a cycle when a commit stores its block.
// A pop of a linear block gives AXIS_COUNT result words, one per axis; every
// other item gives one. Each result sits in an output register; the sequencer
// waits while the receiver stalls and resumes when it takes the word. Reset
// clears pointers, staging and registers to their reset values; queue
// memories are not cleared since a pop only reads written entries.
// ----------------------------------------------------------------------------
module stepper_motion_block_queue import smbq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	smbq_in_if.sink     in_ch,
	smbq_out_if.source  out_ch,
	smbq_cfg_if.sink    cfg
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_MUL   = 10'b0000000010,
		S_LDFIN = 10'b0000000100,
		S_DIV   = 10'b0000001000,
		S_CSWP  = 10'b0000010000,
		S_CFIN  = 10'b0000100000,
		S_PRD   = 10'b0001000000,
		S_PSWP  = 10'b0010000000,
		S_PWAIT = 10'b0100000000,
		S_RESP  = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [31:0] spm_q [4];
	logic [31:0] feed_k_q;
	in_word_t    item_q;
	logic [PTR_W-1:0] head_q, tail_q;
	logic [31:0] staged_q [AXIS_COUNT];

	logic [31:0] axis_mem [AMEM_DEPTH];
	logic [63:0] hdr_mem [QUEUE_DEPTH];
	logic [31:0] arg_mem [QUEUE_DEPTH];
	logic [31:0] axis_rd_q;
	logic [63:0] hdr_rd_q;
	logic [31:0] arg_rd_q;

	// shared arithmetic registers
	logic [32:0] mag_q;
	logic [31:0] scale_q;
	logic [64:0] acc_q;
	logic [1:0]  mcnt_q;
	logic        neg_q;
	logic [47:0] dividend_q;
	logic [32:0] rem_q;
	logic [5:0]  dcnt_q;
	logic [30:0] max_q;
	logic [2:0]  ax_q;
	logic [AMEM_W-1:0] abase_q;

	out_word_t ow_q;
	logic      ov_q;

	function automatic out_word_t status_word(input logic [1:0] st, input logic [3:0] fill);
		out_word_t w;
		w = '0;
		w.status = st;
		w.fill_level = fill;
		w.last = 1'b1;
		return w;
	endfunction

	logic [PTR_W-1:0] next_head, next_tail;
	logic full, empty;
	logic [3:0] fill_cur;
	assign next_head = head_q + 1'b1;
	assign next_tail = tail_q + 1'b1;
	assign full      = (next_head == tail_q);
	assign empty     = (head_q == tail_q);
	assign fill_cur  = 4'(head_q - tail_q);

	assign in_ch.ready  = (state_q == S_IDLE) && !ov_q;
	assign cfg.ready    = 1'b1;
	assign out_ch.valid = ov_q;
	assign out_ch.data  = ow_q;

	logic in_take;
	assign in_take = in_ch.valid && in_ch.ready;

	logic [AX_W-1:0] ax_i;
	assign ax_i = ax_q[AX_W-1:0];

	logic [32:0] in_delta;
	assign in_delta = {in_ch.data.target_position[31], in_ch.data.target_position}
		- {in_ch.data.current_position[31], in_ch.data.current_position};

	// load multiplier: one 16-bit half of the scale per step
	logic [15:0] scale_part;
	logic [48:0] part_prod;
	assign scale_part = mcnt_q[0] ? scale_q[31:16] : scale_q[15:0];
	assign part_prod  = {16'd0, mag_q} * {33'd0, scale_part};

	// divider step
	logic [32:0] rem_sh;
	logic        rem_ge;
	assign rem_sh = {rem_q[31:0], dividend_q[47]};
	assign rem_ge = (rem_sh >= {1'b0, item_q.feed_rate});

	// Quotient bits above 32 mean saturation; a zero rate does too.
	logic [31:0] feed_cyc;
	assign feed_cyc = (item_q.feed_rate == '0 || dividend_q[47:32] != '0)
		? 32'hFFFFFFFF : dividend_q[31:0];

	// load rounding
	logic [64:0] rnd;
	logic [32:0] rq;
	logic [30:0] mag31;
	assign rnd   = acc_q + 65'h80000000;
	assign rq    = rnd[64:32];
	assign mag31 = (rq > 33'h7FFFFFFF) ? 31'h7FFFFFFF : rq[30:0];

	logic out_free, out_load;
	assign out_free = !ov_q || out_ch.ready;
	assign out_load = out_free && (state_q == S_RESP || state_q == S_PSWP);

	out_word_t pop_word;
	always_comb begin
		pop_word = '0;
		pop_word.fill_level = fill_cur;
		if (hdr_rd_q[63]) begin
			pop_word.mcode_flag   = 1'b1;
			pop_word.out_mcode    = hdr_rd_q[39:32];
			pop_word.out_speed    = hdr_rd_q[31:0];
			pop_word.out_argument = arg_rd_q;
			pop_word.last         = 1'b1;
		end else begin
			pop_word.out_axis    = ax_q;
			pop_word.step_count  = axis_rd_q[30:0];
			pop_word.direction   = !axis_rd_q[31];
			pop_word.peak_steps  = hdr_rd_q[62:32];
			pop_word.feed_cycles = hdr_rd_q[31:0];
			pop_word.last        = (ax_q == 3'(AXIS_COUNT - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CSWP) begin
			axis_mem[abase_q + AMEM_W'(ax_q)] <= staged_q[ax_i];
		end
		if (state_q == S_CFIN) begin
			hdr_mem[head_q] <= {1'b0, max_q, feed_cyc};
		end
		if (state_q == S_IDLE && in_take && in_ch.data.kind == KIND_MCODE && !full) begin
			hdr_mem[head_q] <= {1'b1, 23'd0, in_ch.data.mcode_number,
				in_ch.data.spindle_speed};
			arg_mem[head_q] <= in_ch.data.mcode_argument;
		end
		// The header of the popped slot is captured once and held for all its words.
		if (state_q == S_PRD) begin
			hdr_rd_q <= hdr_mem[tail_q];
			arg_rd_q <= arg_mem[tail_q];
		end
		axis_rd_q <= axis_mem[abase_q + AMEM_W'(ax_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			spm_q[0] <= 32'd5242880;
			spm_q[1] <= 32'd5242880;
			spm_q[2] <= 32'd5242880;
			spm_q[3] <= 32'd5242880;
			feed_k_q <= 32'd1000000;
			head_q   <= '0;
			tail_q   <= '0;
			for (int i = 0; i < AXIS_COUNT; i++) staged_q[i] <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.data.index)
					REG_SPM_X:  spm_q[0] <= cfg.data.data;
					REG_SPM_Y:  spm_q[1] <= cfg.data.data;
					REG_SPM_Z:  spm_q[2] <= cfg.data.data;
					REG_SPD:    spm_q[3] <= cfg.data.data;
					REG_FEED_K: feed_k_q <= cfg.data.data;
					default: ;
				endcase
			end
			if (out_load) ov_q <= 1'b1;
			else if (out_ch.ready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						item_q <= in_ch.data;
						case (kind_t'(in_ch.data.kind))
							KIND_LOAD: begin
								ow_q <= status_word(ST_OK, fill_cur);
								if (in_ch.data.axis_index < 3'(AXIS_COUNT)) begin
									neg_q   <= in_delta[32];
									mag_q   <= in_delta[32] ? (~in_delta + 33'd1) : in_delta;
									scale_q <= spm_q[(in_ch.data.axis_index > 3'd3)
										? 2'd3 : in_ch.data.axis_index[1:0]];
									acc_q   <= '0;
									mcnt_q  <= '0;
									state_q <= S_MUL;
								end else begin
									state_q <= S_RESP;
								end
							end
							KIND_COMMIT: begin
								if (full) begin
									ow_q    <= status_word(ST_FULL, fill_cur);
									state_q <= S_RESP;
								end else begin
									dividend_q <= {feed_k_q, 16'd0};
									rem_q   <= '0;
									dcnt_q  <= '0;
									state_q <= S_DIV;
								end
							end
							KIND_MCODE: begin
								if (full) begin
									ow_q <= status_word(ST_FULL, fill_cur);
								end else begin
									head_q <= next_head;
									ow_q   <= status_word(ST_OK, 4'(next_head - tail_q));
								end
								state_q <= S_RESP;
							end
							default: begin
								if (empty) begin
									ow_q    <= status_word(ST_EMPTY, fill_cur);
									state_q <= S_RESP;
								end else begin
									abase_q <= AMEM_W'(tail_q * AXIS_COUNT);
									ax_q    <= '0;
									state_q <= S_PRD;
								end
							end
						endcase
					end
				end
				S_MUL: begin
					// 33-bit magnitude times 32 bits, 16 bits of scale per step
					acc_q  <= acc_q + (mcnt_q[0] ? {part_prod, 16'd0} : {16'd0, part_prod});
					mcnt_q <= mcnt_q + 2'd1;
					if (mcnt_q == 2'd1) state_q <= S_LDFIN;
				end
				S_LDFIN: begin
					staged_q[item_q.axis_index[AX_W-1:0]] <=
						{neg_q && (mag31 != '0), mag31};
					state_q <= S_RESP;
				end
				S_DIV: begin
					dividend_q <= {dividend_q[46:0], rem_ge};
					rem_q <= rem_ge ? rem_sh - {1'b0, item_q.feed_rate} : rem_sh;
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd47) begin
						max_q   <= '0;
						ax_q    <= '0;
						abase_q <= AMEM_W'(head_q * AXIS_COUNT);
						state_q <= S_CSWP;
					end
				end
				S_CSWP: begin
					if (staged_q[ax_i][30:0] > max_q) max_q <= staged_q[ax_i][30:0];
					staged_q[ax_i] <= '0;
					if (ax_q == 3'(AXIS_COUNT - 1)) state_q <= S_CFIN;
					else ax_q <= ax_q + 3'd1;
				end
				S_CFIN: begin
					head_q  <= next_head;
					ow_q    <= status_word(ST_OK, 4'(next_head - tail_q));
					state_q <= S_RESP;
				end
				S_PRD: begin
					// read registers settle for slot and first axis
					tail_q  <= next_tail;
					state_q <= S_PSWP;
				end
				S_PSWP: begin
					if (out_free) begin
						ow_q <= pop_word;
						if (hdr_rd_q[63] || ax_q == 3'(AXIS_COUNT - 1)) begin
							state_q <= S_IDLE;
						end else begin
							ax_q    <= ax_q + 3'd1;
							state_q <= S_PWAIT;
						end
					end
				end
				S_PWAIT: begin
					// lets the axis read register fetch the next entry
					state_q <= S_PSWP;
				end
				S_RESP: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### test/tb_stepper_motion_block_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_motion_block_queue: self-checking bench for the motion block queue
// Drives load, commit, M-code and pop words with random gaps on both sides,
// predicts every result word from a local model of the queue and the staging,
// and compares each one field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_stepper_motion_block_queue;
	import smbq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 600;

	logic clk;
	logic arst_n;

	smbq_in_if  in_ch ();
	smbq_out_if out_ch ();
	smbq_cfg_if cfg ();

	stepper_motion_block_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Local copy of the block's registers and queue.
	logic [31:0] scale_reg [0:3];
	logic [31:0] feed_k;
	logic [31:0] staged [0:AXIS_COUNT-1];
	logic [31:0] axis_mem [0:QUEUE_DEPTH*AXIS_COUNT-1];
	logic [63:0] header_mem [0:QUEUE_DEPTH-1];
	logic [31:0] arg_mem [0:QUEUE_DEPTH-1];
	int unsigned head_ptr, tail_ptr;

	in_word_t  pending_words [$];
	out_word_t expected_words [$];

	int error_count;
	int cycle_count;
	int send_idle_pct, recv_idle_pct;
	int stall_req, stall_done, hold_left;

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		error_count++;
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
	endtask

	function automatic logic [3:0] fill_now();
		return 4'((head_ptr + QUEUE_DEPTH - tail_ptr) % QUEUE_DEPTH);
	endfunction

	function automatic out_word_t status_word(logic [1:0] st);
		out_word_t w;
		w = '0;
		w.status = st;
		w.fill_level = fill_now();
		w.last = 1'b1;
		return w;
	endfunction

	// Applies one accepted word to the model and queues its results.
	task automatic predict_queue(in_word_t w);
		int unsigned nxt;
		longint signed delta;
		logic [63:0] mag, prod, rnd, cyc;
		logic [30:0] maxs;
		logic [63:0] hdr;
		logic neg;
		out_word_t o;
		int unsigned slot;
		nxt = (head_ptr + 1) % QUEUE_DEPTH;
		case (kind_t'(w.kind))
			KIND_LOAD: begin
				if (w.axis_index < AXIS_COUNT) begin
					delta = longint'(signed'(w.target_position))
						- longint'(signed'(w.current_position));
					neg = delta < 0;
					mag = neg ? 64'(-delta) : 64'(delta);
					prod = mag * {32'd0, scale_reg[w.axis_index > 3 ? 3 : w.axis_index]};
					rnd = (prod + 64'h8000_0000) >> 32;
					if (rnd > 64'h7FFF_FFFF) rnd = 64'h7FFF_FFFF;
					if (rnd == 0) neg = 1'b0;
					staged[w.axis_index] = {neg, rnd[30:0]};
				end
				expected_words.push_back(status_word(ST_OK));
			end
			KIND_COMMIT: begin
				if (nxt == tail_ptr) begin
					expected_words.push_back(status_word(ST_FULL));
				end else begin
					if (w.feed_rate == 0) begin
						cyc = 64'hFFFF_FFFF;
					end else begin
						cyc = ({32'd0, feed_k} << 16) / {32'd0, w.feed_rate};
						if (cyc > 64'hFFFF_FFFF) cyc = 64'hFFFF_FFFF;
					end
					maxs = '0;
					for (int i = 0; i < AXIS_COUNT; i++) begin
						axis_mem[head_ptr*AXIS_COUNT + i] = staged[i];
						if (staged[i][30:0] > maxs) maxs = staged[i][30:0];
						staged[i] = '0;
					end
					header_mem[head_ptr] = {1'b0, maxs, cyc[31:0]};
					head_ptr = nxt;
					expected_words.push_back(status_word(ST_OK));
				end
			end
			KIND_MCODE: begin
				if (nxt == tail_ptr) begin
					expected_words.push_back(status_word(ST_FULL));
				end else begin
					header_mem[head_ptr] = {1'b1, 23'd0, w.mcode_number, w.spindle_speed};
					arg_mem[head_ptr] = w.mcode_argument;
					head_ptr = nxt;
					expected_words.push_back(status_word(ST_OK));
				end
			end
			default: begin
				if (head_ptr == tail_ptr) begin
					expected_words.push_back(status_word(ST_EMPTY));
				end else begin
					slot = tail_ptr;
					hdr = header_mem[slot];
					tail_ptr = (tail_ptr + 1) % QUEUE_DEPTH;
					if (hdr[63]) begin
						o = status_word(ST_OK);
						o.mcode_flag = 1'b1;
						o.out_mcode = hdr[39:32];
						o.out_speed = hdr[31:0];
						o.out_argument = arg_mem[slot];
						expected_words.push_back(o);
					end else begin
						for (int i = 0; i < AXIS_COUNT; i++) begin
							o = status_word(ST_OK);
							o.out_axis = 3'(i);
							o.step_count = axis_mem[slot*AXIS_COUNT + i][30:0];
							o.direction = ~axis_mem[slot*AXIS_COUNT + i][31];
							o.peak_steps = hdr[62:32];
							o.feed_cycles = hdr[31:0];
							o.last = (i == AXIS_COUNT - 1);
							expected_words.push_back(o);
						end
					end
				end
			end
		endcase
	endtask

	// Driver: offers pending words, with random gaps between them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) predict_queue(in_ch.data);
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_ch.valid <= 1'b1;
					in_ch.data <= pending_words.pop_front();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_req != stall_done) begin
				stall_done <= stall_req;
				hold_left <= HOLD_CYCLES;
				out_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Monitor: every accepted result word is checked against the oldest prediction.
	always @(posedge clk) begin
		out_word_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_words.size() == 0) begin
				report("unexpected word", 64'(got.status), 64'd0);
			end else begin
				want = expected_words.pop_front();
				if (got.status !== want.status)
					report("status", 64'(got.status), 64'(want.status));
				if (got.mcode_flag !== want.mcode_flag)
					report("mcode_flag", 64'(got.mcode_flag), 64'(want.mcode_flag));
				if (got.out_axis !== want.out_axis)
					report("out_axis", 64'(got.out_axis), 64'(want.out_axis));
				if (got.step_count !== want.step_count)
					report("step_count", 64'(got.step_count), 64'(want.step_count));
				if (got.direction !== want.direction)
					report("direction", 64'(got.direction), 64'(want.direction));
				if (got.peak_steps !== want.peak_steps)
					report("peak_steps", 64'(got.peak_steps), 64'(want.peak_steps));
				if (got.feed_cycles !== want.feed_cycles)
					report("feed_cycles", 64'(got.feed_cycles), 64'(want.feed_cycles));
				if (got.out_mcode !== want.out_mcode)
					report("out_mcode", 64'(got.out_mcode), 64'(want.out_mcode));
				if (got.out_speed !== want.out_speed)
					report("out_speed", 64'(got.out_speed), 64'(want.out_speed));
				if (got.out_argument !== want.out_argument)
					report("out_argument", 64'(got.out_argument), 64'(want.out_argument));
				if (got.fill_level !== want.fill_level)
					report("fill_level", 64'(got.fill_level), 64'(want.fill_level));
				if (got.last !== want.last) report("last", 64'(got.last), 64'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("stepper_motion_block_queue verification failed");
			$finish;
		end
	end

	// Half the time wide values, otherwise corners or small moves.
	function automatic logic [31:0] rand_value();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'(signed'($urandom_range(8)) - 4);
			3: return 32'(signed'($urandom_range(2000000)) - 1000000);
			default: return $urandom();
		endcase
	endfunction

	function automatic in_word_t rand_word(kind_t k);
		in_word_t w;
		w.kind = k;
		w.axis_index = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
			: 3'($urandom_range(AXIS_COUNT - 1));
		w.target_position = rand_value();
		w.current_position = rand_value();
		w.feed_rate = ($urandom_range(19) == 0) ? 32'd0 : $urandom();
		w.mcode_number = 8'($urandom());
		w.spindle_speed = $urandom();
		w.mcode_argument = $urandom();
		return w;
	endfunction

	function automatic in_word_t load_word(int ax, logic [31:0] tgt, logic [31:0] cur);
		in_word_t w;
		w = rand_word(KIND_LOAD);
		w.axis_index = 3'(ax);
		w.target_position = tgt;
		w.current_position = cur;
		return w;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= '{index: idx, data: val};
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx <= REG_SPD) scale_reg[idx[1:0]] = val;
		else if (idx == REG_FEED_K) feed_k = val;
	endtask

	task automatic wait_quiet();
		while (pending_words.size() > 0 || in_ch.valid || expected_words.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Random traffic: mostly loads followed by a commit, some M-codes and pops.
	task automatic queue_random(int count, int pop_pct);
		in_word_t w;
		int sent;
		int r;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(99);
			if (r < pop_pct) begin
				pending_words.push_back(rand_word(KIND_POP));
				sent++;
			end else if (r < pop_pct + 15) begin
				pending_words.push_back(rand_word(KIND_MCODE));
				sent++;
			end else begin
				repeat ($urandom_range(5)) begin
					pending_words.push_back(rand_word(KIND_LOAD));
					sent++;
				end
				// A few sequences are left open so staging carries over.
				if ($urandom_range(9) != 0) begin
					pending_words.push_back(rand_word(KIND_COMMIT));
					sent++;
				end
			end
		end
	endtask

	initial begin
		in_word_t w;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		error_count = 0;
		cycle_count = 0;
		stall_req = 0;
		stall_done = 0;
		hold_left = 0;
		send_idle_pct = 17;
		recv_idle_pct = 79;
		for (int i = 0; i < 4; i++) scale_reg[i] = 32'd5242880;
		feed_k = 32'd1000000;
		for (int i = 0; i < AXIS_COUNT; i++) staged[i] = '0;
		head_ptr = 0;
		tail_ptr = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: corners of every axis, zero-step and ignored loads, feed corners.
		pending_words.push_back(rand_word(KIND_POP));
		pending_words.push_back(load_word(0, 32'h7FFF_FFFF, 32'h8000_0000));
		pending_words.push_back(load_word(1, 32'h8000_0000, 32'h7FFF_FFFF));
		pending_words.push_back(load_word(2, 32'd0, 32'd1));
		pending_words.push_back(load_word(3, 32'h0001_0000, 32'd0));
		pending_words.push_back(load_word(4, 32'hFFFF_0000, 32'd0));
		pending_words.push_back(load_word(7, 32'h7FFF_FFFF, 32'd0));
		w = rand_word(KIND_COMMIT);
		w.feed_rate = 32'd0;
		pending_words.push_back(w);
		w.feed_rate = 32'd1;
		pending_words.push_back(w);
		w.feed_rate = 32'hFFFF_FFFF;
		pending_words.push_back(w);
		w = rand_word(KIND_MCODE);
		w.mcode_number = 8'hFF;
		w.spindle_speed = 32'hFFFF_FFFF;
		w.mcode_argument = 32'hFFFF_FFFF;
		pending_words.push_back(w);
		w.mcode_number = 8'h00;
		w.spindle_speed = 32'h0;
		w.mcode_argument = 32'h0;
		pending_words.push_back(w);
		// Fill the queue with M-codes until several are rejected, then a load and a rejected commit.
		repeat (QUEUE_DEPTH - 3) pending_words.push_back(rand_word(KIND_MCODE));
		pending_words.push_back(rand_word(KIND_MCODE));
		pending_words.push_back(load_word(0, 32'h0010_0000, 32'd0));
		pending_words.push_back(rand_word(KIND_COMMIT));
		repeat (QUEUE_DEPTH + 1) pending_words.push_back(rand_word(KIND_POP));
		wait_quiet();

		// Extreme scales: zero on X, full on Y and Z, one on the rotaries.
		write_reg(REG_SPM_X, 32'd0);
		write_reg(REG_SPM_Y, 32'hFFFF_FFFF);
		write_reg(REG_SPM_Z, 32'hFFFF_FFFF);
		write_reg(REG_SPD, 32'd1);
		write_reg(REG_FEED_K, 32'd1);
		write_reg(3'd6, 32'h1234_5678);
		queue_random(115, 30);
		wait_quiet();

		send_idle_pct = 79;
		recv_idle_pct = 17;
		write_reg(REG_SPM_X, $urandom());
		write_reg(REG_SPM_Y, 32'h0001_0000);
		write_reg(REG_SPM_Z, $urandom());
		write_reg(REG_SPD, 32'hFFFF_FFFF);
		write_reg(REG_FEED_K, 32'hFFFF_FFFF);
		queue_random(105, 20);
		wait_quiet();

		// No idling; a long receiver hold-off lets the queue back up.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_SPM_X, 32'd5242880);
		write_reg(REG_SPD, $urandom());
		write_reg(REG_FEED_K, $urandom_range(2000000, 1));
		queue_random(115, 35);
		stall_req = stall_req + 1;
		wait_quiet();

		if (error_count == 0) begin
			$display("stepper_motion_block_queue verification clean");
		end else begin
			$display("stepper_motion_block_queue verification failed");
		end
		$finish;
	end
endmodule

### files.f
hw/rtl/smbq_pkg.sv
hw/rtl/smbq_if.sv
hw/rtl/stepper_motion_block_queue.sv
test/tb_stepper_motion_block_queue.sv
